// File: rtl/gradient_edge_color_coder_core_assert.svh
// Assertion macros shared by the edge color coder RTL
`ifndef GRADIENT_EDGE_COLOR_CODER_CORE_ASSERT_SVH
`define GRADIENT_EDGE_COLOR_CODER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define GECC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset
`define GECC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/gecc_pkg.sv
// Shared types and constants of the gradient edge color coder
`timescale 1ns / 1ps
`default_nettype none

package gecc_pkg;

   localparam int MAX_QUADS_DEF = 320;

   localparam logic [8:0]  WIDTH_RESET  = 9'd80;
   localparam logic [8:0]  HEIGHT_RESET = 9'd120;
   localparam logic [17:0] THRESH_RESET = 18'd0;

   localparam int CSR_ADDR_W = 4;

   // register index, taken from paddr[3:2]
   typedef enum logic [1:0] {
      REG_WIDTH  = 2'd0,
      REG_HEIGHT = 2'd1,
      REG_THRESH = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [7:0] u_val;
      logic [7:0] y_left;
      logic [7:0] v_val;
      logic [7:0] y_right;
   } req_beat_type;

   typedef struct packed {
      logic [7:0] seg_code;
      logic [8:0] out_col;
      logic [8:0] out_row;
      logic       run_last;
      logic       frame_last;
   } rsp_beat_type;

endpackage

`default_nettype wire

// File: rtl/gecc_line_bank.sv
// One row bank of the line store: one read port, one write port, read-first
`timescale 1ns / 1ps
`default_nettype none

module gecc_line_bank #(
   parameter int DEPTH = gecc_pkg::MAX_QUADS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [31:0]              rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [31:0]              wr_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/gradient_edge_color_coder_core.sv
// Top level of the gradient edge color coder: counters, line store, gradients, result register
//
//   channel | direction | handshake         | beat
//   req     | in        | req_valid/stall   | one UYVY quad (gecc_pkg::req_beat_type)
//   rsp     | out       | rsp_valid/stall   | one code byte + position (rsp_beat_type)
//   csr     | in        | APB psel/penable  | width_quads, height_rows, edge_threshold
//
// One quad per cycle while req_stall is low; each last-row beat below row 0 gives two results.
// The row banks are read at the accepting edge, the gradients are formed on the read data and
// the code is registered once the result register is free. Synchronous reset clears counters,
// pipeline valids and configuration registers; the line store is not cleared. rsp_stall
// reaches req_stall only once the gradient stage holds a beat.
`timescale 1ns / 1ps
`default_nettype none
`include "gradient_edge_color_coder_core_assert.svh"

module gradient_edge_color_coder_core #(
   parameter int MAX_QUADS = gecc_pkg::MAX_QUADS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire gecc_pkg::req_beat_type              req_beat,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output gecc_pkg::rsp_beat_type                   rsp_beat,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [gecc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [31:0]                         csr_pwdata,
   output logic [31:0]                              csr_prdata,
   output logic                                     csr_pready
);

   import gecc_pkg::*;

   localparam int AW = $clog2(MAX_QUADS);
   localparam logic [9:0]  MAX_CLAMP = (MAX_QUADS > 511) ? 10'd511 : 10'(MAX_QUADS);
   localparam logic [10:0] MAX_WIDE  = 11'(MAX_QUADS);

   function automatic logic [17:0] grad_sq(input logic [31:0] p, input logic [31:0] q);
      logic [8:0]  ya;
      logic [8:0]  yb;
      logic [8:0]  dy;
      logic [7:0]  du;
      logic [7:0]  dv;
      logic [17:0] dy2;
      logic [15:0] du2;
      logic [15:0] dv2;
      ya  = {1'b0, p[23:16]} + {1'b0, p[7:0]};
      yb  = {1'b0, q[23:16]} + {1'b0, q[7:0]};
      dy  = (ya > yb) ? ya - yb : yb - ya;
      du  = (p[31:24] > q[31:24]) ? p[31:24] - q[31:24] : q[31:24] - p[31:24];
      dv  = (p[15:8] > q[15:8]) ? p[15:8] - q[15:8] : q[15:8] - p[15:8];
      dy2 = {9'd0, dy} * {9'd0, dy};
      du2 = {8'd0, du} * {8'd0, du};
      dv2 = {8'd0, dv} * {8'd0, dv};
      return {2'b00, dy2[17:2]} + {2'b00, du2} + {2'b00, dv2};
   endfunction

   // ---------------- configuration registers ----------------
   logic [8:0]  width_ff;
   logic [8:0]  height_ff;
   logic [17:0] thresh_ff;
   logic        csr_write;
   reg_index_type csr_index;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         thresh_ff <= THRESH_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_WIDTH:  width_ff  <= csr_pwdata[8:0];
            REG_HEIGHT: height_ff <= csr_pwdata[8:0];
            REG_THRESH: thresh_ff <= csr_pwdata[17:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_WIDTH:  csr_prdata = {23'd0, width_ff};
         REG_HEIGHT: csr_prdata = {23'd0, height_ff};
         REG_THRESH: csr_prdata = {14'd0, thresh_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   // ---------------- position counters ----------------
   logic [8:0] col_ff;
   logic [8:0] row_ff;
   logic [8:0] col_in;
   logic [8:0] row_in;
   logic [8:0] w_eff;
   logic [8:0] h_eff;
   logic [8:0] cur_col;
   logic [8:0] cur_row;
   logic [9:0] col_p1;
   logic [9:0] row_p1;
   logic       restart;
   logic       req_fire;

   assign w_eff   = (width_ff == 9'd0) ? 9'd1 :
                    (width_ff > MAX_CLAMP[8:0]) ? MAX_CLAMP[8:0] : width_ff;
   assign h_eff   = (height_ff == 9'd0) ? 9'd1 : height_ff;
   assign restart = (col_ff >= w_eff) || (row_ff >= h_eff);
   assign cur_col = restart ? 9'd0 : col_ff;
   assign cur_row = restart ? 9'd0 : row_ff;
   assign col_p1  = {1'b0, cur_col} + 10'd1;
   assign row_p1  = {1'b0, cur_row} + 10'd1;

   always_comb begin
      if (col_p1 < {1'b0, w_eff}) begin
         col_in = col_p1[8:0];
         row_in = cur_row;
      end else begin
         col_in = 9'd0;
         row_in = (row_p1 < {1'b0, h_eff}) ? row_p1[8:0] : 9'd0;
      end
   end

   assign req_fire = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= 9'd0;
         row_ff <= 9'd0;
      end else if (req_fire) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------- line store: one bank per row parity ----------------
   logic [AW-1:0] up_addr;
   logic [AW-1:0] nb_addr;
   logic [31:0]   bank_rd [2];
   logic [31:0]   cur_word;
   logic          par;

   assign cur_word = req_beat;
   assign par      = cur_row[0];
   assign up_addr  = AW'(cur_col);
   // column c+1 of the row above; beyond the store it is never an interior neighbor
   assign nb_addr  = ({1'b0, col_p1} < MAX_WIDE) ? AW'(col_p1) : '0;

   for (genvar b = 0; b < 2; b++) begin : g_bank
      gecc_line_bank #(
         .DEPTH(MAX_QUADS)
      ) u_bank (
         .clock   (clock),
         .rd_en   (req_fire),
         .rd_addr ((par == 1'(b)) ? up_addr : nb_addr),
         .rd_data (bank_rd[b]),
         .wr_en   (req_fire && (par == 1'(b))),
         .wr_addr (up_addr),
         .wr_data (cur_word)
      );
   end

   // column 0 of the row above is never read back; keep a copy of it
   logic [31:0] col0_cur_ff;
   logic [31:0] col0_prev_ff;

   always_ff @(posedge clock) begin
      if (req_fire && (cur_col == 9'd0)) begin
         col0_prev_ff <= col0_cur_ff;
         col0_cur_ff  <= cur_word;
      end
   end

   // ---------------- gradient stage ----------------
   logic        s1_valid_ff;
   logic [8:0]  s1_col_ff;
   logic [8:0]  s1_row_ff;
   logic        s1_par_ff;
   logic        s1_emit_a_ff;
   logic        s1_emit_b_ff;
   logic        s1_inner_ff;
   logic        s1_left0_ff;
   logic        s1_flast_ff;
   logic [31:0] s1_cur_ff;
   logic        s1_adv;
   logic        ob_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
      if (req_fire) begin
         s1_col_ff    <= cur_col;
         s1_row_ff    <= cur_row;
         s1_par_ff    <= par;
         s1_emit_a_ff <= (cur_row != 9'd0);
         s1_emit_b_ff <= (row_p1 == {1'b0, h_eff});
         s1_inner_ff  <= (cur_col != 9'd0) && (col_p1 < {1'b0, w_eff}) && (cur_row >= 9'd2);
         s1_left0_ff  <= (cur_col == 9'd1);
         s1_flast_ff  <= (col_p1 == {1'b0, w_eff});
         s1_cur_ff    <= cur_word;
      end
   end

   logic [31:0] up_word;
   logic [31:0] right_word;
   logic [31:0] left_word;
   logic [31:0] win_left_ff;
   logic [31:0] win_mid_ff;
   logic [17:0] grad_v;
   logic [17:0] grad_h;
   logic [7:0]  code_in;

   assign up_word    = s1_par_ff ? bank_rd[1] : bank_rd[0];
   assign right_word = s1_par_ff ? bank_rd[0] : bank_rd[1];
   assign left_word  = s1_left0_ff ? col0_prev_ff : win_left_ff;
   assign grad_v     = grad_sq(s1_cur_ff, up_word);
   assign grad_h     = grad_sq(right_word, left_word);
   assign code_in    = s1_inner_ff ?
                       {grad_v > thresh_ff, grad_h > thresh_ff, win_mid_ff[31:29],
                        win_mid_ff[15:13]} : 8'd0;

   // advance the window over the row above, one column per beat
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         win_left_ff <= win_mid_ff;
         win_mid_ff  <= right_word;
      end
   end

   assign s1_adv    = s1_valid_ff && (!(s1_emit_a_ff || s1_emit_b_ff) || ob_free);
   assign req_stall = s1_valid_ff && !s1_adv;

   // ---------------- result register ----------------
   logic       pend_a_ff;
   logic       pend_b_ff;
   logic [7:0] ob_code_ff;
   logic [8:0] ob_col_ff;
   logic [8:0] ob_row_ff;
   logic       ob_flast_ff;
   logic       rsp_fire;
   logic       ob_load;

   assign rsp_valid = pend_a_ff || pend_b_ff;
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign ob_free   = !rsp_valid || (rsp_fire && !(pend_a_ff && pend_b_ff));
   assign ob_load   = s1_valid_ff && (s1_emit_a_ff || s1_emit_b_ff) && ob_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_a_ff <= 1'b0;
         pend_b_ff <= 1'b0;
      end else if (ob_load) begin
         pend_a_ff <= s1_emit_a_ff;
         pend_b_ff <= s1_emit_b_ff;
      end else if (rsp_fire) begin
         if (pend_a_ff) begin
            pend_a_ff <= 1'b0;
         end else begin
            pend_b_ff <= 1'b0;
         end
      end
      if (ob_load) begin
         ob_code_ff  <= code_in;
         ob_col_ff   <= s1_col_ff;
         ob_row_ff   <= s1_row_ff;
         ob_flast_ff <= s1_flast_ff;
      end
   end

   always_comb begin
      rsp_beat.out_col = ob_col_ff;
      if (pend_a_ff) begin
         rsp_beat.seg_code   = ob_code_ff;
         rsp_beat.out_row    = ob_row_ff - 9'd1;
         rsp_beat.run_last   = !pend_b_ff;
         rsp_beat.frame_last = 1'b0;
      end else begin
         rsp_beat.seg_code   = 8'd0;
         rsp_beat.out_row    = ob_row_ff;
         rsp_beat.run_last   = 1'b1;
         rsp_beat.frame_last = ob_flast_ff;
      end
   end

   // ---------------- assertions ----------------
   `GECC_ASSERT_NEXT(a_pair_follows, clock, reset, rsp_fire && !rsp_beat.run_last, rsp_valid, "second result of a beat lost")
   `GECC_ASSERT_SAME(a_flast_is_last, clock, reset, rsp_valid && rsp_beat.frame_last, rsp_beat.run_last, "frame_last without run_last")
   `GECC_ASSERT_NEXT(a_col_in_frame, clock, reset, req_fire, col_ff < $past(w_eff), "column counter left the frame")
   `GECC_ASSERT_SAME(a_no_drop, clock, reset, ob_load, !rsp_valid || rsp_fire, "result register overwritten")

endmodule

`default_nettype wire
